>>> hdl/pie_pkg.sv
// Shared types and constants for the packed identifier encoder.
// No dependencies; used by pie_pack and packed_id_encoder.
package pie_pkg;

  localparam int unsigned SEQ_MAX   = 9;
  localparam int unsigned ID_BYTES  = 8;
  localparam int unsigned LEN_W     = 4;

  localparam logic [7:0] LAZY_MASK_SHORT = 8'h0F;
  localparam logic [7:0] LAZY_MASK_LONG  = 8'hFF;
  localparam logic       MODE_FULL       = 1'b1;

  typedef logic [SEQ_MAX-1:0][7:0] seq_bytes_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    seq_bytes_t       bytes;
  } pack_item_t;

endpackage

>>> hdl/pie_pack.sv
// Three-stage packing pipeline: capture, mask/length, byte compaction.
// Depends on pie_pkg.
module pie_pack (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         id_low,
  input  logic [31:0]         id_high,
  input  logic                mode,
  output logic                out_valid,
  input  logic                out_ready,
  output pie_pkg::pack_item_t out_item
);

  logic        s1_v_r;
  logic [63:0] s1_id_r;
  logic        s1_mode_r;

  logic        s2_v_r;
  logic [63:0] s2_id_r;
  logic [7:0]  s2_mask_r;
  logic [pie_pkg::LEN_W-1:0] s2_len_r;

  logic                s3_v_r;
  pie_pkg::pack_item_t s3_item_r;

  logic ready1, ready2, ready3;

  logic [7:0]                s2_mask_nxt;
  logic [pie_pkg::LEN_W-1:0] s2_len_nxt;
  pie_pkg::seq_bytes_t       s3_bytes_nxt;

  assign ready3   = !s3_v_r || out_ready;
  assign ready2   = !s2_v_r || ready3;
  assign ready1   = !s1_v_r || ready2;
  assign in_ready = ready1;

  always_comb begin
    logic [7:0] nz;
    nz = '0;
    for (int i = 0; i < pie_pkg::ID_BYTES; i++) begin
      nz[i] = (s1_id_r[8*i +: 8] != 8'h00);
    end
    if (s1_mode_r == pie_pkg::MODE_FULL) begin
      s2_mask_nxt = nz;
    end else if (s1_id_r[63:32] != 32'h0) begin
      s2_mask_nxt = pie_pkg::LAZY_MASK_LONG;
    end else begin
      s2_mask_nxt = pie_pkg::LAZY_MASK_SHORT;
    end
    s2_len_nxt = pie_pkg::LEN_W'(1);
    for (int i = 0; i < pie_pkg::ID_BYTES; i++) begin
      s2_len_nxt = s2_len_nxt + pie_pkg::LEN_W'(s2_mask_nxt[i]);
    end
  end

  always_comb begin
    logic [2:0] pos;
    pos          = '0;
    s3_bytes_nxt = '0;
    s3_bytes_nxt[0] = s2_mask_r;
    for (int i = 0; i < pie_pkg::ID_BYTES; i++) begin
      if (s2_mask_r[i]) begin
        s3_bytes_nxt[pie_pkg::LEN_W'(pos) + pie_pkg::LEN_W'(1)] = s2_id_r[8*i +: 8];
        pos = pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (ready1) begin
        s1_v_r <= in_valid;
      end
      if (ready2) begin
        s2_v_r <= s1_v_r;
      end
      if (ready3) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ready1) begin
      s1_id_r   <= {id_high, id_low};
      s1_mode_r <= mode;
    end
    if (s1_v_r && ready2) begin
      s2_id_r   <= s1_id_r;
      s2_mask_r <= s2_mask_nxt;
      s2_len_r  <= s2_len_nxt;
    end
    if (s2_v_r && ready3) begin
      s3_item_r.len   <= s2_len_r;
      s3_item_r.bytes <= s3_bytes_nxt;
    end
  end

  assign out_valid = s3_v_r;
  assign out_item  = s3_item_r;

endmodule

>>> hdl/packed_id_encoder.sv
// Packed identifier encoder: a 64-bit identifier in, a mask byte and its
// kept bytes out. Depends on pie_pkg and pie_pack.
//
// Usage:
//   in_*  : one beat carries one identifier, id_low in tdata[31:0] and
//           id_high in tdata[63:32].
//   out_* : one beat per packed byte; the mask byte comes first (tuser high)
//           and tlast marks the final byte of the sequence. tdata[11:8]
//           carries the sequence length on every beat.
//   cfg_* : cfg_wr_en writes full_pack_mode from cfg_wr_data (1 = drop zero
//           bytes, 0 = fixed 5- or 9-byte form). Write only while idle.
// The mask byte passes the packing stages, the serialiser and the output register.
// Throughput: the byte-wide serialiser sends all of a sequence (1 to 9 bytes)
//   before it loads the next identifier, which it may load as the last byte
//   goes; the three packing stages take a new identifier every cycle unless stalled.
// Reset: all stages empty, full_pack_mode = 1.
// Stall: while out_tready is low the output beat holds; the serialiser and
//   the packing stages fill up and then hold in_tready low. Nothing is lost.
module packed_id_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] id_low, [63:32] id_high
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [11:8] seq_length, [15:12] zero
  output logic        out_tuser,  // is_mask_byte
  output logic        out_tlast,  // last_byte
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data // full_pack_mode
);

  logic cfg_mode_r;

  logic                pk_valid;
  logic                pk_ready;
  pie_pkg::pack_item_t pk_item;

  logic                      ser_v_r;
  pie_pkg::seq_bytes_t       ser_seq_r;
  logic [pie_pkg::LEN_W-1:0] ser_rem_r;
  logic [pie_pkg::LEN_W-1:0] ser_len_r;
  logic                      ser_first_r;

  logic                      out_valid_r;
  logic [7:0]                out_byte_r;
  logic [pie_pkg::LEN_W-1:0] out_len_r;
  logic                      out_mask_r;
  logic                      out_last_r;

  logic out_free, emit, ser_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r <= pie_pkg::MODE_FULL;
    end else if (cfg_wr_en) begin
      cfg_mode_r <= cfg_wr_data;
    end
  end

  pie_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .id_low    (in_tdata[31:0]),
    .id_high   (in_tdata[63:32]),
    .mode      (cfg_mode_r),
    .out_valid (pk_valid),
    .out_ready (pk_ready),
    .out_item  (pk_item)
  );

  assign out_free = !out_valid_r || out_tready;
  assign emit     = ser_v_r && out_free;
  assign ser_last = (ser_rem_r == pie_pkg::LEN_W'(1));
  assign pk_ready = !ser_v_r || (emit && ser_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pk_ready) begin
        ser_v_r <= pk_valid;
      end
      if (out_free) begin
        out_valid_r <= ser_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pk_ready && pk_valid) begin
      ser_seq_r   <= pk_item.bytes;
      ser_rem_r   <= pk_item.len;
      ser_len_r   <= pk_item.len;
      ser_first_r <= 1'b1;
    end else if (emit) begin
      ser_seq_r   <= {8'h00, ser_seq_r[pie_pkg::SEQ_MAX-1:1]};
      ser_rem_r   <= ser_rem_r - pie_pkg::LEN_W'(1);
      ser_first_r <= 1'b0;
    end
    if (emit) begin
      out_byte_r <= ser_seq_r[0];
      out_len_r  <= ser_len_r;
      out_mask_r <= ser_first_r;
      out_last_r <= ser_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'h0, out_len_r, out_byte_r};
  assign out_tuser  = out_mask_r;
  assign out_tlast  = out_last_r;

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    ser_v_r |-> (ser_rem_r != '0) && (ser_rem_r <= ser_len_r))
    else $error("serialiser remaining count out of range");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    pk_valid |-> (pk_item.len != '0) && (pk_item.len <= pie_pkg::LEN_W'(pie_pkg::SEQ_MAX)))
    else $error("packed length out of range");

  a_single_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser && (out_tdata[11:8] == 4'd1)) |-> out_tlast)
    else $error("one-byte sequence without last flag");

  a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (!out_tvalid || out_tuser))
    else $error("sequence does not restart with a mask byte");

  a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !ser_last) |=> ser_v_r)
    else $error("serialiser dropped a sequence early");

endmodule
